@@ design/hepg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hepg_pkg
// shared constants, types and sha-256 helpers for the entropy pool generator
// ----------------------------------------------------------------------------
package hepg_pkg;

    localparam int JITTER_THRESHOLD = 128;
    localparam int CNT_W = $clog2(2 * JITTER_THRESHOLD + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(2 * JITTER_THRESHOLD);
    localparam logic [CNT_W-1:0] CNT_THR = CNT_W'(JITTER_THRESHOLD);

    localparam logic [1:0] FUNC_STIR = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_GEN  = 2'd2;

    // which message the datapath hashes next
    typedef enum logic [1:0] {
        MSG_DATA  = 2'd0,   // pool || n data bytes
        MSG_CNT   = 2'd1,   // pool || counter
        MSG_ONE   = 2'd2,   // pool || 0x01
        MSG_DIFF  = 2'd3    // pool || tick difference
    } msg_sel_t;

    typedef struct packed {
        logic     load;       // latch input beat
        logic     start;      // start a compression
        msg_sel_t msg;
        logic     to_pool;    // write digest into pool when done
        logic     to_out;     // write digest into output block when done
        logic     tick_upd;   // update jitter statistics
        logic     cnt_inc;    // bump block counter
    } dp_cmd_t;

    typedef struct packed {
        logic       busy;
        logic [1:0] func;
        logic       tick_stir;
    } dp_sts_t;

    function automatic logic [31:0] krnd(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[i];
    endfunction

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [63:0] bswap64(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) r[8*i +: 8] = v[8*(7-i) +: 8];
        return r;
    endfunction

endpackage

@@ design/hepg_sha_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hepg_sha_core
// single-block sha-256 compression, one round per cycle
// ----------------------------------------------------------------------------
module hepg_sha_core import hepg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [511:0] block,     // big-endian words, word 0 in msbs
    output logic         done,
    output logic [255:0] digest     // h0 in msbs
);

    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [255:0] st_reg, st_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic         run_reg, run_next;
    logic         done_reg, done_next;
    logic [255:0] dig_reg, dig_next;

    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn;
    logic [255:0] nst;
    logic [255:0] fin;

    always_comb begin
        {a, b, c, d, e, f, g, h} = st_reg;
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + krnd(rnd_reg) + w_reg[0];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
        nst = {t1 + t2, a, b, c, d + t1, e, f, g};
        for (int i = 0; i < 8; i++)
            fin[32*i +: 32] = H_INIT[32*i +: 32] + nst[32*i +: 32];
    end

    always_comb begin
        w_next    = w_reg;
        st_next   = st_reg;
        rnd_next  = rnd_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        dig_next  = dig_reg;
        if (start) begin
            for (int i = 0; i < 16; i++) w_next[i] = block[511 - 32*i -: 32];
            st_next  = H_INIT;
            rnd_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            for (int i = 0; i < 15; i++) w_next[i] = w_reg[i+1];
            w_next[15] = wn;
            st_next  = nst;
            rnd_next = rnd_reg + 6'd1;
            if (rnd_reg == 6'd63) begin
                run_next  = 1'b0;
                done_next = 1'b1;
                dig_next  = fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        w_reg   <= w_next;
        st_reg  <= st_next;
        rnd_reg <= rnd_next;
        dig_reg <= dig_next;
    end

    assign done   = done_reg;
    assign digest = dig_reg;

endmodule

@@ design/hepg_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hepg_datapath
// pool, counter, jitter statistics, message builder and output block
// ----------------------------------------------------------------------------
module hepg_datapath import hepg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  dp_cmd_t      cmd,
    input  logic [1:0]   in_func,
    input  logic [63:0]  in_data,
    input  logic [3:0]   in_bytes,
    input  logic         hw_seeded,
    output dp_sts_t      sts,
    output logic [255:0] out_block,
    output logic         rdy
);

    logic [255:0] pool_reg, pool_next;
    logic [63:0]  cnt_reg, cnt_next;
    logic [63:0]  last_ts_reg, last_ts_next;
    logic [15:0]  spread_reg, spread_next;
    logic [CNT_W-1:0] samp_reg, samp_next;
    logic [1:0]   func_reg;
    logic [63:0]  data_reg, diff_reg;
    logic [3:0]   nb_reg;
    logic         tstir_reg;
    logic [255:0] oblk_reg, oblk_next;
    logic         core_done;
    logic [255:0] core_dig;
    logic [511:0] blk;
    logic [63:0]  tail_v;
    logic [3:0]   tail_n;
    logic [63:0]  tail_be;
    logic [255:0] dig_le;
    logic [63:0]  diff_c;

    assign diff_c = in_data - last_ts_reg;

    // message: 32 pool bytes, n tail bytes, 0x80, zeros, bit length
    // a generate always stirs all eight timestamp bytes
    always_comb begin
        unique case (cmd.msg)
            MSG_DATA: begin
                tail_v = data_reg;
                tail_n = (func_reg == FUNC_GEN || nb_reg > 4'd8) ? 4'd8 : nb_reg;
            end
            MSG_CNT:  begin tail_v = cnt_reg;  tail_n = 4'd8; end
            MSG_ONE:  begin tail_v = 64'd1;    tail_n = 4'd1; end
            default:  begin tail_v = diff_reg; tail_n = 4'd8; end
        endcase
        tail_be = '0;
        for (int i = 0; i < 8; i++)
            if (4'(i) < tail_n) tail_be[63 - 8*i -: 8] = tail_v[8*i +: 8];
        blk = '0;
        for (int i = 0; i < 4; i++) blk[511 - 64*i -: 64] = bswap64(pool_reg[64*i +: 64]);
        blk[255:192] = tail_be;
        blk[255 - 8*tail_n -: 8] = 8'h80;
        blk[63:0] = 64'(({28'd0, tail_n} + 32'd32) * 32'd8);
        for (int i = 0; i < 4; i++) dig_le[64*i +: 64] = bswap64(core_dig[255 - 64*i -: 64]);
    end

    hepg_sha_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .block   (blk),
        .done    (core_done),
        .digest  (core_dig)
    );

    always_comb begin
        pool_next    = pool_reg;
        cnt_next     = cnt_reg;
        last_ts_next = last_ts_reg;
        spread_next  = spread_reg;
        samp_next    = samp_reg;
        oblk_next    = oblk_reg;
        if (core_done && cmd.to_pool) pool_next = dig_le;
        if (core_done && cmd.to_out)  oblk_next = dig_le;
        if (cmd.cnt_inc) cnt_next = cnt_reg + 64'd1;
        if (cmd.tick_upd) begin
            last_ts_next = data_reg;
            if (samp_reg != '0)
                spread_next = spread_reg | 16'(diff_reg ^ (diff_reg >> 17));
            if (samp_reg < CNT_MAX) samp_next = samp_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg    <= '0;
            cnt_reg     <= '0;
            last_ts_reg <= '0;
            spread_reg  <= '0;
            samp_reg    <= '0;
        end else begin
            pool_reg    <= pool_next;
            cnt_reg     <= cnt_next;
            last_ts_reg <= last_ts_next;
            spread_reg  <= spread_next;
            samp_reg    <= samp_next;
        end
        oblk_reg <= oblk_next;
        if (cmd.load) begin
            func_reg  <= in_func;
            data_reg  <= in_data;
            nb_reg    <= in_bytes;
            diff_reg  <= diff_c;
            tstir_reg <= (samp_reg != '0) || (diff_c != '0);
        end
    end

    assign sts.busy      = ~core_done;
    assign sts.func      = func_reg;
    assign sts.tick_stir = tstir_reg;
    assign out_block     = oblk_reg;
    assign rdy           = hw_seeded || ((samp_reg >= CNT_THR) && (spread_reg != '0));

endmodule

@@ design/hepg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hepg_ctrl
// sequencer for stir, tick and generate
// ----------------------------------------------------------------------------
module hepg_ctrl import hepg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd,
    output logic       o_push,    // result beat ready for output register
    output logic       o_gen,
    output logic [1:0] o_idx,
    input  logic       o_free
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_H1, S_W1, S_H2, S_W2, S_H3, S_W3, S_UPD, S_EMIT
    } state_t;

    state_t     st_reg, st_next;
    logic [1:0] idx_reg, idx_next;
    msg_sel_t   msg_reg, msg_next;
    logic       gen;

    assign gen = (sts.func == FUNC_GEN);

    always_comb begin
        st_next  = st_reg;
        idx_next = idx_reg;
        msg_next = msg_reg;
        cmd      = '0;
        cmd.msg  = msg_reg;
        o_push   = 1'b0;
        s_ready  = (st_reg == S_IDLE);
        unique case (st_reg)
            S_IDLE: if (s_valid) begin cmd.load = 1'b1; st_next = S_DEC; end
            S_DEC: begin
                idx_next = '0;
                if (sts.func == FUNC_STIR) begin
                    msg_next = MSG_DATA; st_next = S_H3;
                end else if (sts.func == FUNC_TICK) begin
                    msg_next = MSG_DIFF;
                    st_next  = sts.tick_stir ? S_H3 : S_UPD;
                end else if (gen) begin
                    msg_next = MSG_CNT; st_next = S_H1;
                end else st_next = S_EMIT;
            end
            S_H1: begin cmd.start = 1'b1; st_next = S_W1; end
            S_W1: begin
                cmd.to_out = 1'b1;
                if (!sts.busy) begin
                    cmd.cnt_inc = 1'b1; msg_next = MSG_ONE; st_next = S_H2;
                end
            end
            S_H2: begin cmd.start = 1'b1; st_next = S_W2; end
            S_W2: begin
                cmd.to_pool = 1'b1;
                if (!sts.busy) begin msg_next = MSG_DATA; st_next = S_H3; end
            end
            S_H3: begin cmd.start = 1'b1; st_next = S_W3; end
            S_W3: begin
                cmd.to_pool = 1'b1;
                if (!sts.busy) st_next = S_UPD;
            end
            S_UPD: begin
                cmd.tick_upd = (sts.func == FUNC_TICK);
                st_next = S_EMIT;
            end
            S_EMIT: if (o_free) begin
                o_push = 1'b1;
                if (!gen || idx_reg == 2'd3) st_next = S_IDLE;
                else idx_next = idx_reg + 2'd1;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= S_IDLE;
            idx_reg <= '0;
            msg_reg <= MSG_DATA;
        end else begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            msg_reg <= msg_next;
        end
    end

    assign o_gen = gen;
    assign o_idx = idx_reg;

endmodule

@@ design/hash_entropy_pool_generator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_entropy_pool_generator_top
// sha-256 entropy pool with timer jitter gathering and block generator
// ----------------------------------------------------------------------------
// one input beat is handled at a time. a stir or a counted tick runs one
// sha-256 compression on the shared round unit (64 rounds, one per cycle)
// and then emits its result beat; a first tick with zero difference skips
// the hash. a generate runs three compressions back to back (block, then
// stir of 0x01, then stir of the timestamp), then emits four result beats,
// one per cycle while the sink is ready. results leave from an output
// register. hardware_seeded sits at apb address 0.
// ----------------------------------------------------------------------------
module hash_entropy_pool_generator_top import hepg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // apb
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [63:0] s_data,
    input  logic [3:0]  s_data_bytes,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_random_word,
    output logic        m_word_valid,
    output logic        m_last,
    output logic        m_ready_res
);

    logic         hws_reg;
    dp_cmd_t      cmd;
    dp_sts_t      sts;
    logic [255:0] oblk;
    logic         rdy, push, gen, o_free;
    logic [1:0]   idx;
    logic         mv_reg;
    logic [63:0]  mw_reg;
    logic         mwv_reg, ml_reg, mr_reg;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) hws_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 2'd0) hws_reg <= pwdata[0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, hws_reg} : 32'd0;

    hepg_ctrl u_ctrl (
        .aclk (aclk), .aresetn (aresetn),
        .s_valid (s_valid), .s_ready (s_ready),
        .sts (sts), .cmd (cmd),
        .o_push (push), .o_gen (gen), .o_idx (idx), .o_free (o_free)
    );

    hepg_datapath u_dp (
        .aclk (aclk), .aresetn (aresetn), .cmd (cmd),
        .in_func (s_func), .in_data (s_data), .in_bytes (s_data_bytes),
        .hw_seeded (hws_reg), .sts (sts), .out_block (oblk), .rdy (rdy)
    );

    // output register, refilled as soon as the held beat goes
    assign o_free = !mv_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (o_free) mv_reg <= push;
        if (push) begin
            mw_reg  <= gen ? oblk[64*idx +: 64] : 64'd0;
            mwv_reg <= gen;
            ml_reg  <= !gen || idx == 2'd3;
            mr_reg  <= rdy;
        end
    end

    assign m_valid       = mv_reg;
    assign m_random_word = mw_reg;
    assign m_word_valid  = mwv_reg;
    assign m_last        = ml_reg;
    assign m_ready_res   = mr_reg;

endmodule
